// ===== hw/rtl/gksa_pkg.sv =====
// Shared types and constants for the grouped key-sum aggregator.
// Holds the table geometry, field widths, action codes, controller states
// and the command and status bundles between the controller and the datapath.
package gksa_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int SUM_W   = 48;

  // Action codes of an input item.
  localparam logic ACT_ACCUM  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FL_RD,
    S_FL_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture the accepted input item
    logic clr_idx;      // restart the table index
    logic inc_idx;      // step the table index
    logic rd_en;        // read the table entry at the index
    logic sum_wr;       // write the saturated sum back at the index
    logic append;       // add the held item key as a new entry
    logic set_drop;     // note a dropped item key
    logic start_group;  // open a new group with the held item
    logic clear_group;  // return the group state to reset values
    logic out_load;     // load the output register from the read entry
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic act_finish;    // held item is a finish
    logic active;        // a group is open
    logic grp_match;     // held group key equals the current group
    logic idx_at_count;  // index has reached the entry count
    logic idx_last;      // index points at the final entry
    logic key_match;     // read entry key equals the held item key
    logic count_full;    // table holds TABLE_DEPTH entries
    logic out_free;      // output register can take an item this cycle
  } status_t;

endpackage

// ===== hw/rtl/gksa_if.sv =====
// Valid/ready channel interfaces for the grouped key-sum aggregator.
// Depends on gksa_pkg for the field widths.

// Input record channel.
interface gksa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [gksa_pkg::KEY_W-1:0]      group_key;
  logic [gksa_pkg::KEY_W-1:0]      item_key;
  logic signed [gksa_pkg::SCORE_W-1:0] score;

  modport source (output valid, action, group_key, item_key, score, input ready);
  modport sink   (input valid, action, group_key, item_key, score, output ready);
endinterface

// Result entry channel.
interface gksa_out_if;
  logic                            valid;
  logic                            ready;
  logic [gksa_pkg::KEY_W-1:0]      out_group_key;
  logic [gksa_pkg::KEY_W-1:0]      out_item_key;
  logic signed [gksa_pkg::SUM_W-1:0] total;
  logic                            entries_dropped;
  logic                            last;

  modport source (output valid, out_group_key, out_item_key, total, entries_dropped, last,
                  input ready);
  modport sink   (input valid, out_group_key, out_item_key, total, entries_dropped, last,
                  output ready);
endinterface

// ===== hw/rtl/gksa_datapath.sv =====
// Datapath of the grouped key-sum aggregator: held item, group state, entry
// table memories, saturating adder and output register. Depends on gksa_pkg.
module gksa_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  gksa_pkg::cmd_t                  cmd,
  output gksa_pkg::status_t               sts,
  input  logic                            action,
  input  logic [gksa_pkg::KEY_W-1:0]      group_key,
  input  logic [gksa_pkg::KEY_W-1:0]      item_key,
  input  logic signed [gksa_pkg::SCORE_W-1:0] score,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [gksa_pkg::KEY_W-1:0]      out_group_key,
  output logic [gksa_pkg::KEY_W-1:0]      out_item_key,
  output logic signed [gksa_pkg::SUM_W-1:0] total,
  output logic                            entries_dropped,
  output logic                            last
);
  import gksa_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Held input item.
  logic                      h_act;
  logic [KEY_W-1:0]          h_grp;
  logic [KEY_W-1:0]          h_item;
  logic signed [SCORE_W-1:0] h_score;

  // Group state.
  logic [KEY_W-1:0] current_group;
  logic             group_active;
  logic             dropped_flag;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] idx;

  // Entry table and its registered read data.
  logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
  logic signed [SUM_W-1:0] sum_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]        rd_key;
  logic signed [SUM_W-1:0] rd_sum;

  // Write port selection.
  logic                    key_we;
  logic                    sum_we;
  logic [IDX_W-1:0]        wr_addr;
  logic signed [SUM_W-1:0] wr_sum;
  logic signed [SUM_W-1:0] score_ext;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  // Sign-extend the score and form the saturated sum of the read entry.
  always_comb begin
    score_ext = {{(SUM_W-SCORE_W){h_score[SCORE_W-1]}}, h_score};
    sum_wide  = {rd_sum[SUM_W-1], rd_sum} + {score_ext[SUM_W-1], score_ext};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // A new group writes entry zero, an append writes the next free entry and
  // an update writes back at the scan index.
  always_comb begin
    key_we = cmd.start_group || cmd.append;
    sum_we = cmd.start_group || cmd.append || cmd.sum_wr;
    if (cmd.start_group) begin
      wr_addr = '0;
      wr_sum  = score_ext;
    end else if (cmd.append) begin
      wr_addr = entry_count[IDX_W-1:0];
      wr_sum  = score_ext;
    end else begin
      wr_addr = idx[IDX_W-1:0];
      wr_sum  = sum_sat;
    end
  end

  // Table memories with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= h_item;
    end
    if (sum_we) begin
      sum_mem[wr_addr] <= wr_sum;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[idx[IDX_W-1:0]];
      rd_sum <= sum_mem[idx[IDX_W-1:0]];
    end
  end

  // Held input item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      h_act   <= action;
      h_grp   <= group_key;
      h_item  <= item_key;
      h_score <= score;
    end
  end

  // Group state and table index.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_group <= '0;
      group_active  <= 1'b0;
      dropped_flag  <= 1'b0;
      entry_count   <= '0;
      idx           <= '0;
    end else begin
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.start_group) begin
        current_group <= h_grp;
        group_active  <= 1'b1;
        dropped_flag  <= 1'b0;
        entry_count   <= CNT_W'(1);
      end else if (cmd.clear_group) begin
        current_group <= '0;
        group_active  <= 1'b0;
        dropped_flag  <= 1'b0;
        entry_count   <= '0;
      end else begin
        if (cmd.append) begin
          entry_count <= entry_count + 1'b1;
        end
        if (cmd.set_drop) begin
          dropped_flag <= 1'b1;
        end
      end
    end
  end

  // Output register: holds one item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_group_key   <= current_group;
      out_item_key    <= rd_key;
      total           <= rd_sum;
      entries_dropped <= dropped_flag;
      last            <= sts.idx_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.act_finish   = (h_act == ACT_FINISH);
    sts.active       = group_active;
    sts.grp_match    = (h_grp == current_group);
    sts.idx_at_count = (idx == entry_count);
    sts.idx_last     = (idx == entry_count - 1'b1);
    sts.key_match    = (rd_key == h_item);
    sts.count_full   = (entry_count == CNT_W'(TABLE_DEPTH));
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/gksa_ctrl.sv =====
// Controller state machine of the grouped key-sum aggregator.
// Sequences accept, table search and group flush. Depends on gksa_pkg.
module gksa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gksa_pkg::status_t sts,
  output gksa_pkg::cmd_t    cmd
);
  import gksa_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.clr_idx = 1'b1;
        if (!sts.active) begin
          // A finish with no open group does nothing; a record opens one.
          cmd.start_group = !sts.act_finish;
          state_next      = S_IDLE;
        end else if (sts.act_finish || !sts.grp_match) begin
          state_next = S_FL_RD;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts.idx_at_count) begin
          // Key not in the table: append it, or drop it when full.
          cmd.append   = !sts.count_full;
          cmd.set_drop = sts.count_full;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.key_match) begin
          cmd.sum_wr = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_FL_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.inc_idx  = 1'b1;
          if (sts.idx_last) begin
            // Run done: a finish clears the block, a record opens its group.
            cmd.clear_group = sts.act_finish;
            cmd.start_group = !sts.act_finish;
            state_next      = S_IDLE;
          end else begin
            state_next = S_FL_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/grouped_key_sum_aggregator.sv =====
// Top level of the grouped key-sum aggregator.
// Depends on gksa_pkg, gksa_if, gksa_ctrl and gksa_datapath.

// Takes records ordered by group key and sums scores per distinct item key
// within the current group, holding up to TABLE_DEPTH entries in order of
// first appearance; sums saturate at 48 bits and a new key that finds the
// table full is dropped and flagged. When the group key changes, or a finish
// item arrives, every entry of the old group goes out as one run with last on
// the final entry. One item is processed at a time and the table is searched
// through a single memory read port, entry by entry: each entry is read into
// a register and then compared. An item that finds no group open (the first
// record, or a finish with nothing to flush) needs no search. A record of the
// current group stops the scan at the entry with its key and adds to it; when
// its key is not among the entries it is appended or dropped. An item that
// closes a group (a finish, or a record with a new group key) flushes every
// entry and waits while the output is stalled. A finished result waits in
// the output register while the next item is accepted. No clearing pass is
// needed after reset.
module grouped_key_sum_aggregator (
  input logic        clk,
  input logic        rst,
  gksa_in_if.sink    in_ch,
  gksa_out_if.source out_ch
);
  import gksa_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  // Controller.
  gksa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  gksa_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (in_ch.action),
    .group_key       (in_ch.group_key),
    .item_key        (in_ch.item_key),
    .score           (in_ch.score),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_group_key   (out_ch.out_group_key),
    .out_item_key    (out_ch.out_item_key),
    .total           (out_ch.total),
    .entries_dropped (out_ch.entries_dropped),
    .last            (out_ch.last)
  );

  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is still in work");

  // A new entry is only appended to a table that has room.
  assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !sts.count_full)
    else $error("append into a full table");

  // The output register is only loaded when its item has gone or is taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_ch.valid || out_ch.ready)
    else $error("output item overwritten before it was taken");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the grouped key-sum aggregator.
// Depends on gksa_pkg, the gksa_in_if and gksa_out_if channels and the top level;
// expected entries come from a predictor of the group table kept inside this file.
module tb_top;
  import gksa_pkg::*;

  // An emitted table entry, as the block should deliver it.
  typedef struct {
    logic [KEY_W-1:0]        grp;
    logic [KEY_W-1:0]        item;
    logic signed [SUM_W-1:0] total;
    logic                    dropped;
    logic                    last;
  } entry_t;

  // One input record; typed rows carry the single entry they must flush.
  typedef struct {
    logic                      act;
    logic [KEY_W-1:0]          grp;
    logic [KEY_W-1:0]          item;
    logic signed [SCORE_W-1:0] score;
    bit                        typed;
    entry_t                    want;
  } record_t;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [KEY_W-1:0] PAT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KEY_W-1:0] PAT_5 = 64'h5555_5555_5555_5555;
  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gksa_in_if  in_ch ();
  gksa_out_if out_ch ();

  grouped_key_sum_aggregator uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted state of the group table.
  logic [KEY_W-1:0]        tbl_item [TABLE_DEPTH];
  logic signed [SUM_W-1:0] tbl_sum  [TABLE_DEPTH];
  int                      tbl_count = 0;
  logic [KEY_W-1:0]        grp_cur = '0;
  bit                      grp_open = 1'b0;
  bit                      grp_dropped = 1'b0;

  entry_t pending_entries[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     send_idle_pct = 0;
  int     ready_stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(9))
      0: return SCORE_MAX;
      1: return SCORE_MIN;
      default: return $urandom();
    endcase
  endfunction

  function automatic record_t row(input logic act, input logic [KEY_W-1:0] g, i,
                                  input logic signed [SCORE_W-1:0] s);
    record_t r;
    r.act   = act;
    r.grp   = g;
    r.item  = i;
    r.score = s;
    r.typed = 1'b0;
    r.want  = '{default: '0};
    return r;
  endfunction

  function automatic record_t row_typed(input logic act, input logic [KEY_W-1:0] g, i,
                                        input logic signed [SCORE_W-1:0] s,
                                        input logic [KEY_W-1:0] wg, wi,
                                        input logic signed [SUM_W-1:0] wt,
                                        input logic wd, wl);
    record_t r;
    r = row(act, g, i, s);
    r.typed = 1'b1;
    r.want  = '{grp: wg, item: wi, total: wt, dropped: wd, last: wl};
    return r;
  endfunction

  // Queue every entry of the open group as one run, last on the final one.
  function automatic void flush_table();
    for (int k = 0; k < tbl_count; k++) begin
      pending_entries.push_back('{grp: grp_cur, item: tbl_item[k], total: tbl_sum[k],
                                  dropped: grp_dropped, last: (k == tbl_count - 1)});
    end
  endfunction

  function automatic void open_group(input record_t rec);
    grp_cur     = rec.grp;
    grp_open    = 1'b1;
    grp_dropped = 1'b0;
    tbl_item[0] = rec.item;
    tbl_sum[0]  = SUM_W'(rec.score);
    tbl_count   = 1;
  endfunction

  // Advance the table by one accepted record and queue what it flushes.
  function automatic void tally_record(input record_t rec);
    longint acc;
    if (rec.act == ACT_FINISH) begin
      if (grp_open) begin
        flush_table();
        tbl_count   = 0;
        grp_cur     = '0;
        grp_open    = 1'b0;
        grp_dropped = 1'b0;
      end
      return;
    end
    if (!grp_open) begin
      open_group(rec);
      return;
    end
    if (rec.grp != grp_cur) begin
      flush_table();
      open_group(rec);
      return;
    end
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_item[k] == rec.item) begin
        acc = longint'(tbl_sum[k]) + longint'(rec.score);
        if (acc > SUM_HI) acc = SUM_HI;
        else if (acc < SUM_LO) acc = SUM_LO;
        tbl_sum[k] = acc[SUM_W-1:0];
        return;
      end
    end
    if (tbl_count < TABLE_DEPTH) begin
      tbl_item[tbl_count] = rec.item;
      tbl_sum[tbl_count]  = SUM_W'(rec.score);
      tbl_count++;
    end else begin
      grp_dropped = 1'b1;
    end
  endfunction

  // Offer one item after a random gap and wait for it to be taken.
  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_record(input record_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= rec.act;
    in_ch.group_key <= rec.grp;
    in_ch.item_key  <= rec.item;
    in_ch.score     <= rec.score;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tally_record(rec);
    if (rec.typed) begin
      void'(pending_entries.pop_back());
      pending_entries.push_back(rec.want);
    end
    @(negedge clk);
  endtask

  // Hold the input off until every queued entry is out, then let the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Fill the table past its depth so that new keys are dropped, then close the group.
  task automatic fill_table_run(input bit end_with_finish);
    logic [KEY_W-1:0] g;
    logic [KEY_W-1:0] base;
    g = rand_key();
    base = rand_key();
    for (int n = 0; n < TABLE_DEPTH + 2; n++) begin
      send_record(row(ACT_ACCUM, g, base + n, rand_score()));
    end
    send_record(row(ACT_ACCUM, g, base, rand_score()));
    send_record(row(ACT_ACCUM, g, base + TABLE_DEPTH - 1, rand_score()));
    send_record(row(ACT_ACCUM, g, base + TABLE_DEPTH + 7, rand_score()));
    if (end_with_finish) begin
      send_record(row(ACT_FINISH, rand_key(), rand_key(), $urandom()));
    end else begin
      send_record(row(ACT_ACCUM, ~g, rand_key(), rand_score()));
    end
  endtask

  // Groups of random length over small key pools, with stray finish items.
  task automatic random_traffic(input int n_items);
    int               sent;
    int               len;
    int               pool_n;
    logic [KEY_W-1:0] g;
    logic [KEY_W-1:0] pool [48];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_record(row(ACT_FINISH, rand_key(), rand_key(), $urandom()));
        sent++;
      end else begin
        case ($urandom_range(9))
          0: g = '0;
          1: g = '1;
          default: g = rand_key();
        endcase
        if ($urandom_range(99) < 6) begin
          pool_n = $urandom_range(20, 48);
          len = $urandom_range(40, 80);
        end else begin
          pool_n = $urandom_range(1, 8);
          len = $urandom_range(1, 10);
        end
        for (int k = 0; k < pool_n; k++) pool[k] = rand_key();
        for (int k = 0; k < len; k++) begin
          send_record(row(ACT_ACCUM, g, pool[$urandom_range(pool_n - 1)], rand_score()));
        end
        sent += len;
      end
    end
  endtask

  // Receiver side stalls at the rate of the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Compare each delivered entry with the oldest expected one.
  always @(posedge clk) begin : check_entries
    entry_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_entries.size() == 0) begin
        flag_mismatch($sformatf("entry with none expected: group %h item %h total %0d",
                                out_ch.out_group_key, out_ch.out_item_key, out_ch.total));
      end else begin
        want = pending_entries.pop_front();
        if (out_ch.out_group_key !== want.grp)
          flag_mismatch($sformatf("group key %h, expected %h", out_ch.out_group_key, want.grp));
        if (out_ch.out_item_key !== want.item)
          flag_mismatch($sformatf("item key %h, expected %h", out_ch.out_item_key, want.item));
        if (out_ch.total !== want.total)
          flag_mismatch($sformatf("total %0d, expected %0d (item %h)",
                                  out_ch.total, want.total, want.item));
        if (out_ch.entries_dropped !== want.dropped)
          flag_mismatch($sformatf("dropped flag %b, expected %b",
                                  out_ch.entries_dropped, want.dropped));
        if (out_ch.last !== want.last)
          flag_mismatch($sformatf("last %b, expected %b (item %h)",
                                  out_ch.last, want.last, want.item));
      end
    end
  end

  // End the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("grouped_key_sum_aggregator test failed");
      $finish;
    end
  end

  initial begin
    record_t plan[$];

    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ACCUM;
    in_ch.group_key = '0;
    in_ch.item_key  = '0;
    in_ch.score     = '0;
    out_ch.ready    = 1'b0;

    // Directed rows: empty finishes, field extremes, group changes, cancelling sums.
    plan.push_back(row(ACT_FINISH, rand_key(), rand_key(), $urandom()));
    plan.push_back(row(ACT_ACCUM, '0, '0, SCORE_MIN));
    plan.push_back(row_typed(ACT_FINISH, '1, '1, '1,
                             64'd0, 64'd0, 48'shFFFF_8000_0000, 1'b0, 1'b1));
    plan.push_back(row(ACT_FINISH, '0, '0, '0));
    plan.push_back(row(ACT_ACCUM, '1, '1, SCORE_MAX));
    plan.push_back(row(ACT_ACCUM, '1, '1, SCORE_MAX));
    plan.push_back(row(ACT_ACCUM, '1, '0, '0));
    plan.push_back(row(ACT_ACCUM, '1, '1, -1));
    plan.push_back(row(ACT_ACCUM, PAT_5, PAT_A, 32'sh5555_5555));
    plan.push_back(row(ACT_ACCUM, PAT_5, PAT_5, 32'shAAAA_AAAA));
    plan.push_back(row(ACT_ACCUM, PAT_A, 64'd1, 1));
    plan.push_back(row(ACT_ACCUM, PAT_A, 64'd1, -1));
    plan.push_back(row_typed(ACT_ACCUM, '0, 64'd2, 5,
                             PAT_A, 64'd1, 48'sd0, 1'b0, 1'b1));
    plan.push_back(row(ACT_ACCUM, '0, 64'd3, -7));
    plan.push_back(row(ACT_ACCUM, '0, 64'd2, -5));
    plan.push_back(row(ACT_FINISH, '1, '1, '1));
    plan.push_back(row(ACT_ACCUM, 64'd1, 64'd7, 100));
    plan.push_back(row_typed(ACT_ACCUM, 64'd2, 64'd7, 100,
                             64'd1, 64'd7, 48'sd100, 1'b0, 1'b1));
    plan.push_back(row_typed(ACT_FINISH, PAT_A, PAT_5, '0,
                             64'd2, 64'd7, 48'sd100, 1'b0, 1'b1));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) send_record(plan[n]);
    drain_results();

    // Full table: dropped keys, hits on existing keys, and a group change that closes it.
    send_idle_pct = 9;
    ready_stall_pct = 9;
    fill_table_run(1'b0);
    drain_results();

    // Random traffic under each idling pattern, draining between patterns.
    send_idle_pct = 0;
    ready_stall_pct = 0;
    random_traffic(35);
    drain_results();
    send_idle_pct = 64;
    ready_stall_pct = 0;
    random_traffic(35);
    drain_results();
    send_idle_pct = 0;
    ready_stall_pct = 64;
    random_traffic(35);
    drain_results();
    send_idle_pct = 9;
    ready_stall_pct = 9;
    random_traffic(35);
    send_record(row(ACT_FINISH, rand_key(), rand_key(), $urandom()));
    drain_results();

    if (mismatches == 0) begin
      $display("grouped_key_sum_aggregator test passed");
    end else begin
      $display("grouped_key_sum_aggregator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gksa_pkg.sv
hw/rtl/gksa_if.sv
hw/rtl/gksa_datapath.sv
hw/rtl/gksa_ctrl.sv
hw/rtl/grouped_key_sum_aggregator.sv
verif/tb_top.sv
